/* hw/rtl/etag_pkg.sv */
// types and constants shared by the entity tag list matcher
// no dependencies; imported by etag_phase and http_etag_list_matcher
package etag_pkg;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_DIGEST = 2'd1,
        CMD_HEADER = 2'd2,
        CMD_END    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        VERDICT_NONE      = 2'd0,
        VERDICT_MATCH     = 2'd1,
        VERDICT_MALFORMED = 2'd2
    } t_verdict;

    // list parser phases, one-hot
    typedef enum logic [7:0] {
        PH_LEAD  = 8'b0000_0001,
        PH_STAR  = 8'b0000_0010,
        PH_SEP   = 8'b0000_0100,
        PH_W     = 8'b0000_1000,
        PH_OPEN  = 8'b0001_0000,
        PH_TAG   = 8'b0010_0000,
        PH_AFTER = 8'b0100_0000,
        PH_BAD   = 8'b1000_0000
    } t_phase;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_W       = 8'h57;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_STAR    = 8'h2a;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_TAG_MIN = 8'h21;
    localparam logic [7:0] CH_DEL     = 8'h7f;

    // tag events raised by the parser for the digest comparison
    typedef struct packed {
        logic begin_tag;
        logic close_tag;
        logic tag_char;
    } t_tag_ev;

    // parser phase summary used to form the verdict
    typedef struct packed {
        logic lead;
        logic star;
        logic list_ok;
    } t_phase_status;

endpackage

/* hw/rtl/etag_ram.sv */
// generic single-write, single-read RAM with registered read data
// no dependencies
module etag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/etag_phase.sv */
// header value list parser: phase state machine and tag events
// depends on etag_pkg
module etag_phase
    import etag_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_hdr,
    input  logic [7:0]    i_byte,
    output t_tag_ev       o_ev,
    output t_phase_status o_status
);

    t_phase r_phase;
    t_phase n_phase;
    t_phase item_phase;
    logic   blank;
    logic   tag_ok;

    assign blank  = (i_byte == CH_SPACE) || (i_byte == CH_TAB);
    assign tag_ok = (i_byte >= CH_TAG_MIN) && (i_byte != CH_DEL);

    // first byte of a list item
    always_comb begin
        if (blank || i_byte == CH_COMMA) begin
            item_phase = PH_SEP;
        end else if (i_byte == CH_W) begin
            item_phase = PH_W;
        end else if (i_byte == CH_QUOTE) begin
            item_phase = PH_TAG;
        end else begin
            item_phase = PH_BAD;
        end
    end

    always_comb begin
        n_phase = r_phase;
        o_ev    = '0;
        if (i_start) begin
            n_phase = PH_LEAD;
        end else if (i_hdr) begin
            unique case (r_phase)
                PH_LEAD: begin
                    if (blank) begin
                        n_phase = PH_LEAD;
                    end else if (i_byte == CH_STAR) begin
                        n_phase = PH_STAR;
                    end else begin
                        n_phase      = item_phase;
                        o_ev.begin_tag = (i_byte == CH_QUOTE);
                    end
                end
                PH_STAR: begin
                    if (!blank) n_phase = PH_BAD;
                end
                PH_SEP: begin
                    n_phase        = item_phase;
                    o_ev.begin_tag = (i_byte == CH_QUOTE);
                end
                PH_W: begin
                    n_phase = (i_byte == CH_SLASH) ? PH_OPEN : PH_BAD;
                end
                PH_OPEN: begin
                    if (i_byte == CH_QUOTE) begin
                        n_phase        = PH_TAG;
                        o_ev.begin_tag = 1'b1;
                    end else begin
                        n_phase = PH_BAD;
                    end
                end
                PH_TAG: begin
                    if (i_byte == CH_QUOTE) begin
                        n_phase        = PH_AFTER;
                        o_ev.close_tag = 1'b1;
                    end else if (!tag_ok) begin
                        n_phase = PH_BAD;
                    end else begin
                        o_ev.tag_char = 1'b1;
                    end
                end
                PH_AFTER: begin
                    if (i_byte == CH_COMMA) begin
                        n_phase = PH_SEP;
                    end else if (!blank) begin
                        n_phase = PH_BAD;
                    end
                end
                PH_BAD: begin
                    n_phase = PH_BAD;
                end
                default: begin
                    n_phase = PH_BAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEAD;
        end else begin
            r_phase <= n_phase;
        end
    end

    assign o_status.lead    = (r_phase == PH_LEAD);
    assign o_status.star    = (r_phase == PH_STAR);
    assign o_status.list_ok = (r_phase == PH_SEP) || (r_phase == PH_AFTER);

endmodule

/* hw/rtl/http_etag_list_matcher.sv */
// If-None-Match list matcher with weak entity tag comparison, top level
// depends on etag_pkg, etag_ram and etag_phase
//
// One transaction is taken every clock cycle; a stall reaches the input only while a
// verdict sits in the output register and the downstream side stalls. Each header byte
// moves the list parser one step and, in a tag, compares against one digest byte. The
// digest RAM is read at the next tag position into its read register, so the byte for
// the next compare is always ready; a digest write to that address is forwarded. An end
// command's verdict goes to the output register, valid from the cycle after acceptance.
module http_etag_list_matcher
    import etag_pkg::*;
#(
    parameter int DIGEST_MAX = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_verdict
);

    localparam int LW = $clog2(DIGEST_MAX + 1);
    localparam int AW = (DIGEST_MAX > 1) ? $clog2(DIGEST_MAX) : 1;
    localparam logic [LW-1:0] LEN_MAX = LW'(DIGEST_MAX);

    logic          accept;
    logic          cmd_start;
    logic          cmd_digest;
    logic          cmd_header;
    logic          cmd_end;
    t_tag_ev       ev;
    t_phase_status status;

    logic [LW-1:0] r_dlen, n_dlen;
    logic          r_ovf, n_ovf;
    logic [LW-1:0] r_pos, n_pos;
    logic          r_mism, n_mism;
    logic          r_any, n_any;
    logic          r_byp_hit;
    logic [7:0]    r_byp_data;
    logic          r_out_valid;
    t_verdict      r_verdict;
    t_verdict      verdict_now;

    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    ram_rdata;
    logic [7:0]    cur_byte;

    assign o_stall    = r_out_valid && i_stall;
    assign accept     = i_valid && !o_stall;
    assign cmd_start  = accept && (t_cmd'(i_command) == CMD_START);
    assign cmd_digest = accept && (t_cmd'(i_command) == CMD_DIGEST);
    assign cmd_header = accept && (t_cmd'(i_command) == CMD_HEADER);
    assign cmd_end    = accept && (t_cmd'(i_command) == CMD_END);

    etag_phase u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (cmd_start),
        .i_hdr    (cmd_header),
        .i_byte   (i_data_byte),
        .o_ev     (ev),
        .o_status (status)
    );

    assign we    = cmd_digest && (r_dlen < LEN_MAX);
    assign waddr = r_dlen[AW-1:0];
    assign raddr = n_pos[AW-1:0];

    etag_ram #(
        .WIDTH (8),
        .DEPTH (DIGEST_MAX)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_data_byte),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    assign cur_byte = r_byp_hit ? r_byp_data : ram_rdata;

    always_comb begin
        n_dlen = r_dlen;
        n_ovf  = r_ovf;
        n_pos  = r_pos;
        n_mism = r_mism;
        n_any  = r_any;
        if (cmd_start) begin
            n_dlen = '0;
            n_ovf  = 1'b0;
            n_pos  = '0;
            n_mism = 1'b0;
            n_any  = 1'b0;
        end else if (cmd_digest) begin
            if (r_dlen < LEN_MAX) begin
                n_dlen = r_dlen + LW'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end else if (ev.begin_tag) begin
            n_pos  = '0;
            n_mism = 1'b0;
        end else if (ev.close_tag) begin
            if (!r_mism && !r_ovf && r_pos == r_dlen) begin
                n_any = 1'b1;
            end
        end else if (ev.tag_char && !r_mism) begin
            if (r_pos >= r_dlen || cur_byte != i_data_byte) begin
                n_mism = 1'b1;
            end else begin
                n_pos = r_pos + LW'(1);
            end
        end
    end

    always_comb begin
        if (status.lead) begin
            verdict_now = VERDICT_NONE;
        end else if (status.star) begin
            verdict_now = VERDICT_MATCH;
        end else if (status.list_ok) begin
            verdict_now = r_any ? VERDICT_MATCH : VERDICT_NONE;
        end else begin
            verdict_now = VERDICT_MALFORMED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlen      <= '0;
            r_ovf       <= 1'b0;
            r_pos       <= '0;
            r_mism      <= 1'b0;
            r_any       <= 1'b0;
            r_byp_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_dlen <= n_dlen;
            r_ovf  <= n_ovf;
            r_pos  <= n_pos;
            r_mism <= n_mism;
            r_any  <= n_any;
            // ram read is old data when written at the same address
            r_byp_hit <= we && (waddr == raddr);
            if (cmd_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= i_data_byte;
        if (cmd_end) begin
            r_verdict <= verdict_now;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_verdict = r_verdict;

endmodule
